FILE: hdl/gpr_pkg.sv
// Shared types and constants of the GPIO port register block.
`default_nettype none
package gpr_pkg;

	// Register selector codes of the bus access.
	typedef enum logic [2:0] {
		SEL_CFG_LOW  = 3'd0,
		SEL_CFG_HIGH = 3'd1,
		SEL_INPUT    = 3'd2,
		SEL_OUTPUT   = 3'd3,
		SEL_BSRR     = 3'd4,
		SEL_BRR      = 3'd5,
		SEL_LOCK     = 3'd6
	} reg_sel_t;

	// Progress through the lock key sequence.
	typedef enum logic [1:0] {
		KEY_IDLE  = 2'd0,
		KEY_ONE   = 2'd1,
		KEY_ZERO  = 2'd2,
		KEY_ARMED = 2'd3
	} key_stage_t;

	localparam logic [31:0] CFG_RESET   = 32'h4444_4444;
	localparam int          KEY_BIT     = 16;
	localparam int          MAX_PINS    = 16;
	localparam int          FIELD_W     = 4;
	localparam logic [3:0]  FIELD_MASK  = 4'hf;

	// One result transfer; the first member sits in the highest bits.
	typedef struct packed {
		logic        lock_active;
		logic [31:0] pin_modes_high;
		logic [31:0] pin_modes_low;
		logic [15:0] output_levels;
		logic [31:0] read_data;
	} result_t;

	// Internal status of the register file, watched by the top level.
	typedef struct packed {
		logic       locked;
		key_stage_t stage;
	} gpr_status_t;

endpackage
`default_nettype wire

FILE: hdl/gpr_regfile.sv
// Port register file: configuration, output data and lock key logic.
`default_nettype none
module gpr_regfile
	import gpr_pkg::*;
#(
	parameter int PORT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        acc,
	input  wire logic        is_write,
	input  wire logic [2:0]  sel,
	input  wire logic [31:0] wdata,
	input  wire logic [15:0] pins,
	output result_t          res,
	output gpr_status_t      status
);

	logic [31:0] cfg_lo_q, cfg_hi_q, cfg_lo_n, cfg_hi_n;
	logic [15:0] out_q, out_n;
	logic [15:0] mask_q, mask_n;
	key_stage_t  stage_q, stage_n;
	logic        locked_q, locked_n;

	logic [15:0] pm;
	logic [31:0] m_lo, m_hi;
	logic [15:0] lock_low;
	logic [31:0] rd;

	// Present pins and writable configuration fields.
	always_comb begin
		for (int i = 0; i < MAX_PINS; i++) begin
			pm[i] = (i < PORT_WIDTH);
		end
		for (int k = 0; k < 8; k++) begin
			m_lo[k*FIELD_W +: FIELD_W] =
				(pm[k] && !(locked_q && mask_q[k])) ? FIELD_MASK : 4'h0;
			m_hi[k*FIELD_W +: FIELD_W] =
				(pm[k+8] && !(locked_q && mask_q[k+8])) ? FIELD_MASK : 4'h0;
		end
	end

	assign lock_low = wdata[15:0] & pm;

	always_comb begin
		cfg_lo_n = cfg_lo_q;
		cfg_hi_n = cfg_hi_q;
		out_n    = out_q;
		mask_n   = mask_q;
		stage_n  = stage_q;
		locked_n = locked_q;
		rd       = '0;
		if (is_write) begin
			case (reg_sel_t'(sel))
				SEL_CFG_LOW:  cfg_lo_n = (cfg_lo_q & ~m_lo) | (wdata & m_lo);
				SEL_CFG_HIGH: cfg_hi_n = (cfg_hi_q & ~m_hi) | (wdata & m_hi);
				SEL_OUTPUT:   out_n = wdata[15:0] & pm;
				SEL_BSRR:     out_n = ((out_q & ~wdata[31:16]) | wdata[15:0]) & pm;
				SEL_BRR:      out_n = out_q & ~wdata[15:0] & pm;
				SEL_LOCK: begin
					if (!locked_q) begin
						if (wdata[KEY_BIT]) begin
							if (stage_q == KEY_ZERO && lock_low == mask_q) begin
								stage_n = KEY_ARMED;
							end else begin
								mask_n  = lock_low;
								stage_n = KEY_ONE;
							end
						end else begin
							if (stage_q == KEY_ONE && lock_low == mask_q) begin
								stage_n = KEY_ZERO;
							end else begin
								mask_n  = lock_low;
								stage_n = KEY_IDLE;
							end
						end
					end
				end
				default: ;
			endcase
		end else begin
			case (reg_sel_t'(sel))
				SEL_CFG_LOW:  rd = cfg_lo_q;
				SEL_CFG_HIGH: rd = cfg_hi_q;
				SEL_INPUT:    rd = {16'h0, pins & pm};
				SEL_OUTPUT:   rd = {16'h0, out_q};
				SEL_LOCK: begin
					// The read that completes the key shows the key bit as zero.
					if (stage_q == KEY_ARMED) begin
						rd       = {16'h0, mask_q};
						locked_n = 1'b1;
					end else begin
						rd = {15'h0, locked_q, mask_q};
					end
					stage_n = KEY_IDLE;
				end
				default: rd = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_lo_q <= CFG_RESET;
			cfg_hi_q <= CFG_RESET;
			out_q    <= '0;
			mask_q   <= '0;
			stage_q  <= KEY_IDLE;
			locked_q <= 1'b0;
		end else if (acc) begin
			cfg_lo_q <= cfg_lo_n;
			cfg_hi_q <= cfg_hi_n;
			out_q    <= out_n;
			mask_q   <= mask_n;
			stage_q  <= stage_n;
			locked_q <= locked_n;
		end
	end

	assign res.read_data      = rd;
	assign res.output_levels  = out_n;
	assign res.pin_modes_low  = cfg_lo_n;
	assign res.pin_modes_high = cfg_hi_n;
	assign res.lock_active    = locked_n;

	assign status.locked = locked_q;
	assign status.stage  = stage_q;

endmodule
`default_nettype wire

FILE: hdl/gpio_port_registers_unit.sv
// Top level of the GPIO port register block with its result skid stage.
// Results are registered in the output slot, or in the skid slot if the output slot is held.
// Throughput: one access per cycle while the skid slot is free, set by the single register file update.
// A skid register lets one more access be taken while a result waits.
// Reset (arst_n low, asynchronous): config words 0x44444444, output and lock
// state cleared, both result slots empty.
`default_nettype none
module gpio_port_registers_unit
	import gpr_pkg::*;
#(
	parameter int PORT_WIDTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [47:0]  s_tdata,   // write_data[31:0], pin_levels[47:32]
	input  wire logic [3:0]   s_tuser,   // action[0], reg_select[3:1]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [119:0]      m_tdata    // read_data[31:0], output_levels[47:32],
	                                     // pin_modes_low[79:48], pin_modes_high[111:80],
	                                     // lock_active[112], zero fill above
);

	logic        accept;
	logic        take;
	result_t     res_new;
	result_t     res_q;
	result_t     skid_q;
	logic        vld_q;
	logic        skid_vld_q;
	gpr_status_t status;

	// Input is taken whenever the skid slot is free.
	assign s_tready = !skid_vld_q;
	assign accept   = s_tvalid && s_tready;
	assign take     = vld_q && m_tready;

	// Every register update and the result it produces happen in the accept cycle.
	gpr_regfile #(
		.PORT_WIDTH(PORT_WIDTH)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (accept),
		.is_write (s_tuser[0]),
		.sel      (s_tuser[3:1]),
		.wdata    (s_tdata[31:0]),
		.pins     (s_tdata[47:32]),
		.res      (res_new),
		.status   (status)
	);

	// Control of the output slot and the skid slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (accept) begin
			// The skid slot is empty here, since accept needs it free.
			if (!vld_q || take) begin
				vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				vld_q <= 1'b0;
			end
		end
	end

	// Result payload, no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!vld_q || take) begin
				res_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end else if (take && skid_vld_q) begin
			res_q <= skid_q;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {7'h0, res_q};

	// A waiting skid entry always sits behind a held output entry.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> vld_q)
		else $error("skid slot holds a result while the output slot is empty");

	// An accepted access always leaves a result on the master side.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted access produced no result");

	// Once locked, the port stays locked until reset.
	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.locked |=> status.locked)
		else $error("lock released without reset");

	// After locking, no key sequence can be in progress.
	a_locked_idle: assert property (@(posedge clk) disable iff (!arst_n)
		status.locked |-> (status.stage == KEY_IDLE))
		else $error("key sequence advanced while locked");

endmodule
`default_nettype wire
